// ----- rtl/bta_pkg.sv -----
// Shared widths and codes for the boundary-tag allocator.
package bta_pkg;

  // Width of the request and response address and size fields
  localparam int unsigned FIELD_W = 11;

  // Split slack register width and its value after reset
  localparam int unsigned SLACK_W = 10;
  localparam logic [SLACK_W-1:0] SLACK_RESET = 10'd10;

  // Request action codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

endpackage

// ----- rtl/bta_req_if.sv -----
// Request channel: allocate or free command.
interface bta_req_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [bta_pkg::FIELD_W-1:0]  request_size;
  logic [bta_pkg::FIELD_W-1:0]  free_addr;

  modport source (output valid, output action, output request_size, output free_addr,
                  input ready);
  modport sink (input valid, input action, input request_size, input free_addr,
                output ready);
endinterface

// ----- rtl/bta_rsp_if.sv -----
// Response channel: outcome of one request.
interface bta_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [bta_pkg::FIELD_W-1:0]  block_addr;
  logic [bta_pkg::FIELD_W-1:0]  block_size;

  modport source (output valid, output ok, output block_addr, output block_size,
                  input ready);
  modport sink (input valid, input ok, input block_addr, input block_size,
                output ready);
endinterface

// ----- rtl/bta_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
module bta_ram #(
  parameter int unsigned WIDTH = 34,
  parameter int unsigned DEPTH = 1026
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- rtl/boundary_tag_allocator_core.sv -----
// Boundary-tag first-fit allocator: sequencer over the tagged word store.
//
//  channel   dir  handshake         payload
//  req_i     in   valid/ready       action, request_size, free_addr
//  rsp_o     out  valid/ready       ok, block_addr, block_size
//  cfg       in   cfg_we_i          cfg_wdata_i (split_slack)
//
// An allocate is accepted, then walks the free list one node per cycle and runs
// a read-modify-write program; a free reads the header, the footer and both
// neighbor tags, then runs an update program of reads and read-modify-writes.
// Both then close the update and load the output register. Each read-modify-write
// reads its word through the single read port, then writes the merged word back.
// After reset a clearing pass writes all POOL_WORDS+2 words, one per cycle,
// before the first request is taken. A waiting response does not block the
// next request; a finished result waits only if the output register is full.
module boundary_tag_allocator_core #(
  parameter int unsigned POOL_WORDS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bta_req_if.sink                       req_i,
  bta_rsp_if.source                     rsp_o,
  input  logic                          cfg_we_i,
  input  logic [bta_pkg::SLACK_W-1:0]   cfg_wdata_i
);

  localparam int unsigned STORE_LEN = POOL_WORDS + 2;
  localparam int unsigned AW   = $clog2(STORE_LEN);
  localparam int unsigned EAW  = AW + 1;
  localparam int unsigned CW   = ((AW > bta_pkg::FIELD_W) ? AW : bta_pkg::FIELD_W) + 1;
  localparam int unsigned CNTW = $clog2(STORE_LEN + 1);
  localparam int unsigned WW   = 1 + 3 * AW;
  localparam int unsigned FW   = bta_pkg::FIELD_W;

  typedef struct packed {
    logic          tag;
    logic [AW-1:0] size;
    logic [AW-1:0] link;
    logic [AW-1:0] rlink;
  } word_t;

  typedef enum logic [1:0] {OP_END, OP_RD, OP_RMW} op_kind_e;
  typedef enum logic [1:0] {SZ_KEEP, SZ_SET, SZ_ADD, SZ_SUB} sz_mode_e;

  typedef struct packed {
    op_kind_e       kind;
    logic [EAW-1:0] addr;
    logic           set_tag;
    logic           tag;
    logic           set_link;
    logic [AW-1:0]  link;
    logic           set_rlink;
    logic [AW-1:0]  rlink;
    sz_mode_e       sz_mode;
    logic [AW-1:0]  sz_val;
    logic           cap;
  } op_t;

  typedef enum logic [2:0] {
    PR_WHOLE, PR_SPLIT, PR_F_EMPTY, PR_F_LL, PR_F_LO, PR_F_HI, PR_F_BOTH
  } prog_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_WALK, ST_F_HDR, ST_F_FTR, ST_F_LEFT, ST_F_RIGHT,
    ST_OP_ISSUE, ST_OP_DATA, ST_RESULT
  } state_e;

  state_e                      state_q;
  logic [AW-1:0]               clr_q;
  logic [bta_pkg::SLACK_W-1:0] slack_q;
  logic [AW-1:0]               head_q, hnew_q;
  logic                        empty_q;
  logic [EAW-1:0]              p_q, f_q, t_q, g_q, last_q;
  logic [FW-1:0]               n_q;
  logic [AW-1:0]               sz_q, lnk_q, rlk_q, s_q, tsz_q;
  logic                        lt_q;
  word_t                       x_q;
  prog_e                       prog_q;
  logic [2:0]                  step_q;
  logic [CNTW-1:0]             cnt_q;
  logic                        oos_q;
  logic                        res_ok_q;
  logic [FW-1:0]               res_addr_q, res_size_q;
  logic                        out_valid_q, out_ok_q;
  logic [FW-1:0]               out_addr_q, out_size_q;

  // Store access
  logic            rd_en, wr_en;
  logic [EAW-1:0]  rd_addr, wr_addr;
  word_t           wr_word, init_word;
  logic [WW-1:0]   ram_rdata;
  word_t           rdw;
  op_t             op;
  word_t           merged;

  logic            req_acc;
  logic [CW-1:0]   n_c, fa_c, p_c, last_c, sz_c, size_c;
  logic [AW-1:0]   n_a, pa;

  function automatic logic [EAW-1:0] ea(input logic [AW-1:0] x);
    return {1'b0, x};
  endfunction

  assign req_acc = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.ok         = out_ok_q;
  assign rsp_o.block_addr = out_addr_q;
  assign rsp_o.block_size = out_size_q;

  // Out-of-store words read as zero
  assign rdw = oos_q ? word_t'('0) : word_t'(ram_rdata);

  assign n_c    = CW'(n_q);
  assign n_a    = n_c[AW-1:0];
  assign pa     = p_q[AW-1:0];
  assign fa_c   = CW'(req_i.free_addr);
  assign p_c    = CW'(p_q);
  assign last_c = CW'(last_q);
  assign sz_c   = CW'(sz_q);
  assign size_c = CW'(rdw.size);

  // Reset image of one store word
  always_comb begin
    init_word = '0;
    if (clr_q == AW'(0) || clr_q == AW'(POOL_WORDS + 1)) begin
      init_word.tag = 1'b1;
    end
    if (clr_q == AW'(1)) begin
      init_word.size  = AW'(POOL_WORDS);
      init_word.link  = AW'(1);
      init_word.rlink = AW'(1);
    end
    if (clr_q == AW'(POOL_WORDS)) begin
      init_word.link = AW'(1);
    end
  end

  // Micro-op of the current update program
  always_comb begin
    op = '0;
    op.kind = OP_END;
    op.sz_mode = SZ_KEEP;
    case (prog_q)
      PR_WHOLE: begin
        case (step_q)
          3'd0: begin
            op.kind = OP_RMW; op.addr = ea(rlk_q); op.set_link = 1'b1; op.link = lnk_q;
          end
          3'd1: begin
            op.kind = OP_RMW; op.addr = ea(lnk_q); op.set_rlink = 1'b1; op.rlink = rlk_q;
          end
          3'd2: begin
            op.kind = OP_RMW; op.addr = p_q; op.set_tag = 1'b1; op.tag = 1'b1;
          end
          3'd3: begin
            op.kind = OP_RMW; op.addr = f_q; op.set_tag = 1'b1; op.tag = 1'b1;
          end
          default: op.kind = OP_END;
        endcase
      end
      PR_SPLIT: begin
        case (step_q)
          3'd0: begin
            op.kind = OP_RMW; op.addr = f_q; op.set_tag = 1'b1; op.tag = 1'b1;
          end
          3'd1: begin
            op.kind = OP_RMW; op.addr = p_q; op.sz_mode = SZ_SUB; op.sz_val = n_a;
            op.cap = 1'b1;
          end
          3'd2: begin
            op.kind = OP_RMW; op.addr = p_q + ea(x_q.size) - EAW'(1);
            op.set_tag = 1'b1; op.tag = 1'b0; op.set_link = 1'b1; op.link = pa;
          end
          3'd3: begin
            op.kind = OP_RMW; op.addr = last_q + EAW'(1);
            op.set_tag = 1'b1; op.tag = 1'b1; op.sz_mode = SZ_SET; op.sz_val = n_a;
          end
          default: op.kind = OP_END;
        endcase
      end
      PR_F_EMPTY: begin
        case (step_q)
          3'd0: begin
            op.kind = OP_RMW; op.addr = p_q; op.set_tag = 1'b1;
            op.set_link = 1'b1; op.link = pa; op.set_rlink = 1'b1; op.rlink = pa;
          end
          3'd1: begin
            op.kind = OP_RMW; op.addr = f_q; op.set_tag = 1'b1;
            op.set_link = 1'b1; op.link = pa;
          end
          default: op.kind = OP_END;
        endcase
      end
      PR_F_LL: begin
        case (step_q)
          3'd0: begin
            op.kind = OP_RMW; op.addr = p_q; op.set_tag = 1'b1;
          end
          3'd1: begin
            op.kind = OP_RMW; op.addr = f_q; op.set_tag = 1'b1;
            op.set_link = 1'b1; op.link = pa;
          end
          3'd2: begin
            op.kind = OP_RD; op.addr = ea(head_q);
          end
          3'd3: begin
            op.kind = OP_RMW; op.addr = ea(x_q.link); op.set_rlink = 1'b1; op.rlink = pa;
          end
          3'd4: begin
            op.kind = OP_RMW; op.addr = p_q; op.set_link = 1'b1; op.link = x_q.link;
            op.set_rlink = 1'b1; op.rlink = head_q;
          end
          3'd5: begin
            op.kind = OP_RMW; op.addr = ea(head_q); op.set_link = 1'b1; op.link = pa;
          end
          default: op.kind = OP_END;
        endcase
      end
      PR_F_LO: begin
        case (step_q)
          3'd0: begin
            op.kind = OP_RMW; op.addr = ea(s_q); op.sz_mode = SZ_ADD; op.sz_val = sz_q;
          end
          3'd1: begin
            op.kind = OP_RMW; op.addr = f_q; op.set_tag = 1'b1;
            op.set_link = 1'b1; op.link = s_q;
          end
          default: op.kind = OP_END;
        endcase
      end
      PR_F_HI: begin
        case (step_q)
          3'd0: begin
            op.kind = OP_RMW; op.addr = p_q; op.set_tag = 1'b1;
            op.set_link = 1'b1; op.link = lnk_q;
          end
          3'd1: begin
            op.kind = OP_RMW; op.addr = ea(lnk_q); op.set_rlink = 1'b1; op.rlink = pa;
          end
          3'd2: begin
            op.kind = OP_RD; op.addr = t_q;
          end
          3'd3: begin
            op.kind = OP_RMW; op.addr = p_q; op.set_rlink = 1'b1; op.rlink = x_q.rlink;
          end
          3'd4: begin
            op.kind = OP_RMW; op.addr = ea(x_q.rlink); op.set_link = 1'b1; op.link = pa;
          end
          3'd5: begin
            op.kind = OP_RMW; op.addr = p_q; op.sz_mode = SZ_ADD; op.sz_val = tsz_q;
          end
          3'd6: begin
            op.kind = OP_RMW; op.addr = g_q; op.set_link = 1'b1; op.link = pa;
          end
          default: op.kind = OP_END;
        endcase
      end
      PR_F_BOTH: begin
        case (step_q)
          3'd0: begin
            op.kind = OP_RMW; op.addr = ea(s_q); op.sz_mode = SZ_ADD;
            op.sz_val = sz_q + tsz_q;
          end
          3'd1: begin
            op.kind = OP_RMW; op.addr = ea(lnk_q); op.set_rlink = 1'b1; op.rlink = rlk_q;
          end
          3'd2: begin
            op.kind = OP_RMW; op.addr = ea(rlk_q); op.set_link = 1'b1; op.link = lnk_q;
          end
          3'd3: begin
            op.kind = OP_RMW; op.addr = g_q; op.set_link = 1'b1; op.link = s_q;
          end
          default: op.kind = OP_END;
        endcase
      end
      default: op.kind = OP_END;
    endcase
  end

  // Apply the micro-op to the word just read
  always_comb begin
    merged = rdw;
    if (op.set_tag) begin
      merged.tag = op.tag;
    end
    if (op.set_link) begin
      merged.link = op.link;
    end
    if (op.set_rlink) begin
      merged.rlink = op.rlink;
    end
    case (op.sz_mode)
      SZ_SET:  merged.size = op.sz_val;
      SZ_ADD:  merged.size = rdw.size + op.sz_val;
      SZ_SUB:  merged.size = rdw.size - op.sz_val;
      default: merged.size = rdw.size;
    endcase
  end

  // Store port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_word = merged;
    case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = ea(clr_q);
        wr_word = init_word;
      end
      ST_IDLE: begin
        if (req_acc) begin
          rd_en = 1'b1;
          if (req_i.action == bta_pkg::ACT_ALLOC) begin
            rd_addr = ea(head_q);
          end else begin
            rd_addr = fa_c[EAW-1:0];
          end
        end
      end
      ST_WALK: begin
        rd_en   = 1'b1;
        rd_addr = ea(rdw.rlink);
      end
      ST_F_HDR: begin
        rd_en   = 1'b1;
        rd_addr = p_q + ea(rdw.size) - EAW'(1);
      end
      ST_F_FTR: begin
        rd_en   = 1'b1;
        rd_addr = p_q - EAW'(1);
      end
      ST_F_LEFT: begin
        rd_en   = 1'b1;
        rd_addr = p_q + ea(sz_q);
      end
      ST_OP_ISSUE: begin
        rd_en   = (op.kind != OP_END);
        rd_addr = op.addr;
      end
      ST_OP_DATA: begin
        wr_en   = (op.kind == OP_RMW) && !oos_q;
        wr_addr = last_q;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  bta_ram #(
    .WIDTH (WW),
    .DEPTH (STORE_LEN)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr[AW-1:0]),
    .wdata_i (wr_word),
    .re_i    (rd_en),
    .raddr_i (rd_addr[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Sequencer, list state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      slack_q     <= bta_pkg::SLACK_RESET;
      head_q      <= AW'(1);
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
      oos_q       <= 1'b0;
      step_q      <= '0;
      prog_q      <= PR_WHOLE;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        slack_q <= cfg_wdata_i;
      end
      if (rd_en) begin
        oos_q <= (rd_addr >= EAW'(STORE_LEN));
      end
      // drop the response once taken, unless a new one loads this cycle
      if (out_valid_q && rsp_o.ready && state_q != ST_RESULT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(STORE_LEN - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_acc) begin
            n_q      <= req_i.request_size;
            res_ok_q <= 1'b0;
            res_addr_q <= '0;
            res_size_q <= '0;
            if (req_i.action == bta_pkg::ACT_ALLOC) begin
              p_q   <= ea(head_q);
              cnt_q <= '0;
              if (empty_q || req_i.request_size == '0) begin
                state_q <= ST_RESULT;
              end else begin
                state_q <= ST_WALK;
              end
            end else begin
              p_q <= fa_c[EAW-1:0];
              if (fa_c == '0 || fa_c > CW'(POOL_WORDS)) begin
                state_q <= ST_RESULT;
              end else begin
                state_q <= ST_F_HDR;
              end
            end
          end
        end
        ST_WALK: begin
          // advance first-fit walk one node per cycle
          if (size_c < n_c && rdw.rlink != head_q && cnt_q < CNTW'(STORE_LEN)) begin
            p_q   <= ea(rdw.rlink);
            cnt_q <= cnt_q + CNTW'(1);
          end else if (size_c < n_c) begin
            state_q <= ST_RESULT;
          end else begin
            sz_q   <= rdw.size;
            lnk_q  <= rdw.link;
            rlk_q  <= rdw.rlink;
            f_q    <= p_q + ea(rdw.size) - EAW'(1);
            hnew_q <= rdw.rlink;
            if (size_c - n_c <= CW'(slack_q)) begin
              prog_q <= PR_WHOLE;
              if (ea(rdw.rlink) == p_q) begin
                empty_q <= 1'b1;
                step_q  <= 3'd2;
              end else begin
                step_q  <= '0;
              end
            end else begin
              prog_q <= PR_SPLIT;
              step_q <= '0;
            end
            state_q <= ST_OP_ISSUE;
          end
        end
        ST_F_HDR: begin
          sz_q <= rdw.size;
          f_q  <= p_q + ea(rdw.size) - EAW'(1);
          if (!rdw.tag || rdw.size == '0 || size_c > CW'(POOL_WORDS)
              || p_c + size_c - CW'(1) > CW'(POOL_WORDS)) begin
            state_q <= ST_RESULT;
          end else begin
            state_q <= ST_F_FTR;
          end
        end
        ST_F_FTR: begin
          if (!rdw.tag) begin
            state_q <= ST_RESULT;
          end else begin
            state_q <= ST_F_LEFT;
          end
        end
        ST_F_LEFT: begin
          s_q     <= rdw.link;
          lt_q    <= rdw.tag;
          t_q     <= p_q + ea(sz_q);
          state_q <= ST_F_RIGHT;
        end
        ST_F_RIGHT: begin
          // pick the merge case from the neighbor tags
          lnk_q  <= rdw.link;
          rlk_q  <= rdw.rlink;
          tsz_q  <= rdw.size;
          g_q    <= t_q + ea(rdw.size) - EAW'(1);
          step_q <= '0;
          if (empty_q) begin
            prog_q  <= PR_F_EMPTY;
            hnew_q  <= pa;
            empty_q <= 1'b0;
          end else if (lt_q && rdw.tag) begin
            prog_q <= PR_F_LL;
            hnew_q <= pa;
          end else if (!lt_q && rdw.tag) begin
            prog_q <= PR_F_LO;
            hnew_q <= head_q;
          end else if (lt_q) begin
            prog_q <= PR_F_HI;
            hnew_q <= (ea(head_q) == t_q) ? pa : head_q;
          end else begin
            prog_q <= PR_F_BOTH;
            hnew_q <= (ea(head_q) == t_q) ? s_q : head_q;
          end
          state_q <= ST_OP_ISSUE;
        end
        ST_OP_ISSUE: begin
          if (op.kind == OP_END) begin
            head_q   <= hnew_q;
            res_ok_q <= 1'b1;
            if (prog_q == PR_SPLIT) begin
              res_addr_q <= last_c[FW-1:0];
              res_size_q <= n_q;
            end else begin
              res_addr_q <= p_c[FW-1:0];
              res_size_q <= sz_c[FW-1:0];
            end
            state_q <= ST_RESULT;
          end else begin
            last_q  <= op.addr;
            state_q <= ST_OP_DATA;
          end
        end
        ST_OP_DATA: begin
          if (op.kind == OP_RD) begin
            x_q <= rdw;
          end else if (op.cap) begin
            x_q <= merged;
          end
          step_q  <= step_q + 3'd1;
          state_q <= ST_OP_ISSUE;
        end
        ST_RESULT: begin
          // hold until the output register is free
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q <= 1'b1;
            out_ok_q    <= res_ok_q;
            out_addr_q  <= res_addr_q;
            out_size_q  <= res_size_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // No request is taken during the clearing pass
  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !req_i.ready)
    else $error("request ready during clearing pass");

  // Store writes stay inside the store
  a_write_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> wr_addr < EAW'(STORE_LEN))
    else $error("store write outside the pool");

  // One request at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_i.ready)
    else $error("second request taken while busy");

  // Walk bounded by the store length
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> cnt_q <= CNTW'(STORE_LEN))
    else $error("free-list walk ran past its bound");

endmodule
